// File: hdl/hrsp_pkg.sv
// Shared types and character constants for the hex register script parser.
package hrsp_pkg;

  localparam logic [7:0] CHAR_NL   = 8'h0a;
  localparam logic [7:0] CHAR_HASH = 8'h23;
  localparam logic [7:0] CHAR_SEMI = 8'h3b;
  localparam logic [7:0] CHAR_X_LC = 8'h78;
  localparam logic [7:0] CHAR_X_UC = 8'h58;

  localparam int unsigned NUM_FIELDS = 4;
  localparam int unsigned REC_WIDTH  = 112;

  typedef enum logic [2:0] {
    MODE_LINE_START,
    MODE_FIELD,
    MODE_GAP,
    MODE_HASH,
    MODE_IGNORE
  } mode_t;

  // The first member lands in the highest bits, so dev_addr ends up lowest.
  typedef struct packed {
    logic        too_many_fields;
    logic [3:0]  bad_hex_mask;
    logic [2:0]  fields_found;
    logic [31:0] delay_value;
    logic [31:0] write_data;
    logic [31:0] target_reg;
    logic [7:0]  dev_addr;
  } record_t;

endpackage

// File: hdl/hex_register_script_parser_core.sv
// Top level of the hex register script parser: input register, parser, output register.
//
// The slave stream carries script text, one byte per transaction. Lines hold up to
// four whitespace-separated hex fields (optional 0x prefix), ';' starts a comment,
// and a '#' in the first column marks a comment line. Each newline of a line that
// is neither empty nor a comment line produces one record transaction on the
// master stream.
// Throughput is one byte per cycle: the byte register feeds the parser state
// update, and the record goes straight into the output register.
// An accepted newline byte passes the byte register, then the output register, to m_axis_tvalid.
// A byte that produces no record never waits on the master side. A newline
// that produces a record waits in the byte register while the output register
// is full and stalled, and s_axis_tready drops until the receiver takes it.
// Reset clears the line state and both valid flags; a final line without a
// newline never produces a record.
module hex_register_script_parser_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,  // [7:0] char_in
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [7:0] dev_addr, [39:8] target_reg, [71:40] write_data, [103:72] delay_value,
  // [106:104] fields_found, [110:107] bad_hex_mask, [111] too_many_fields
  output logic [111:0] m_axis_tdata
);

  logic              in_valid;
  logic [7:0]        in_char;
  logic              advance;
  logic              step;
  logic              emit;
  hrsp_pkg::record_t rec;

  assign advance       = !(emit && m_axis_tvalid && !m_axis_tready);
  assign step          = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char <= s_axis_tdata;
    end
  end

  hrsp_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .char_in (in_char),
    .emit    (emit),
    .rec     (rec)
  );

  hrsp_out_reg u_out_reg (
    .clk           (clk),
    .rst           (rst),
    .load          (step && emit),
    .rec           (rec),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// File: hdl/hrsp_parser.sv
// Line parser: per-byte state update and the record of the current line.
module hrsp_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       char_in,
  output logic             emit,
  output hrsp_pkg::record_t rec
);

  hrsp_pkg::mode_t mode, mode_next;
  logic [2:0]  field_index, field_index_next;
  logic [1:0]  char_position, char_position_next;
  logic [31:0] field_accum [4];
  logic [31:0] field_accum_next [4];
  logic [3:0]  bad_flags, bad_flags_next;
  logic        extra_flag, extra_flag_next;

  logic        take;
  logic        starting;
  logic        clear;
  logic [1:0]  take_k;
  logic [1:0]  eff_pos;
  logic        is_blank;
  logic        is_x;
  logic        dig_ok;
  logic [3:0]  dig_val;

  always_comb begin
    is_blank = (char_in == 8'h20) || (char_in == 8'h09) || (char_in == 8'h0b) ||
               (char_in == 8'h0c) || (char_in == 8'h0d);
    is_x = (char_in == hrsp_pkg::CHAR_X_LC) || (char_in == hrsp_pkg::CHAR_X_UC);
    dig_ok  = 1'b1;
    dig_val = 4'd0;
    if (char_in >= 8'h30 && char_in <= 8'h39) begin
      dig_val = 4'(char_in - 8'h30);
    end else if (char_in >= 8'h61 && char_in <= 8'h66) begin
      dig_val = 4'(char_in - 8'h57);
    end else if (char_in >= 8'h41 && char_in <= 8'h46) begin
      dig_val = 4'(char_in - 8'h37);
    end else begin
      dig_ok = 1'b0;
    end
  end

  assign emit = (char_in == hrsp_pkg::CHAR_NL) && (mode != hrsp_pkg::MODE_LINE_START) &&
                (mode != hrsp_pkg::MODE_HASH);

  always_comb begin
    mode_next          = mode;
    field_index_next   = field_index;
    char_position_next = char_position;
    extra_flag_next    = extra_flag;
    take               = 1'b0;
    starting           = 1'b0;
    clear              = 1'b0;
    take_k             = field_index[1:0] - 2'd1;
    if (step) begin
      if (char_in == hrsp_pkg::CHAR_NL) begin
        clear              = 1'b1;
        mode_next          = hrsp_pkg::MODE_LINE_START;
        field_index_next   = 3'd0;
        char_position_next = 2'd0;
        extra_flag_next    = 1'b0;
      end else begin
        case (mode)
          hrsp_pkg::MODE_LINE_START: begin
            if (char_in == hrsp_pkg::CHAR_HASH) begin
              mode_next = hrsp_pkg::MODE_HASH;
            end else if (char_in == hrsp_pkg::CHAR_SEMI) begin
              mode_next = hrsp_pkg::MODE_IGNORE;
            end else if (is_blank) begin
              field_index_next = 3'd1;
              mode_next        = hrsp_pkg::MODE_GAP;
            end else begin
              field_index_next = 3'd1;
              mode_next        = hrsp_pkg::MODE_FIELD;
              take             = 1'b1;
              starting         = 1'b1;
              take_k           = 2'd0;
            end
          end
          hrsp_pkg::MODE_FIELD: begin
            if (char_in == hrsp_pkg::CHAR_SEMI) begin
              mode_next = hrsp_pkg::MODE_IGNORE;
            end else if (is_blank) begin
              mode_next = hrsp_pkg::MODE_GAP;
            end else begin
              take = 1'b1;
            end
          end
          hrsp_pkg::MODE_GAP: begin
            if (char_in == hrsp_pkg::CHAR_SEMI) begin
              mode_next = hrsp_pkg::MODE_IGNORE;
            end else if (!is_blank) begin
              if (field_index >= 3'(hrsp_pkg::NUM_FIELDS)) begin
                extra_flag_next = 1'b1;
                mode_next       = hrsp_pkg::MODE_IGNORE;
              end else begin
                field_index_next = field_index + 3'd1;
                mode_next        = hrsp_pkg::MODE_FIELD;
                take             = 1'b1;
                starting         = 1'b1;
                take_k           = field_index[1:0];
              end
            end
          end
          default: begin
          end
        endcase
      end
    end

    eff_pos = starting ? 2'd0 : char_position;
    if (take) begin
      char_position_next = (eff_pos < 2'd2) ? eff_pos + 2'd1 : eff_pos;
    end

    for (int i = 0; i < 4; i++) begin
      field_accum_next[i] = field_accum[i];
      bad_flags_next[i]   = bad_flags[i];
      if (clear) begin
        field_accum_next[i] = 32'd0;
        bad_flags_next[i]   = 1'b0;
      end else if (take && take_k == 2'(i)) begin
        if (eff_pos == 2'd1 && is_x && field_accum[i] == 32'd0 && !bad_flags[i]) begin
          field_accum_next[i] = field_accum[i];
        end else if (!bad_flags[i]) begin
          if (!dig_ok) begin
            bad_flags_next[i]   = 1'b1;
            field_accum_next[i] = 32'd0;
          end else begin
            field_accum_next[i] = {field_accum[i][27:0], dig_val};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= hrsp_pkg::MODE_LINE_START;
      field_index   <= 3'd0;
      char_position <= 2'd0;
      bad_flags     <= 4'd0;
      extra_flag    <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        field_accum[i] <= 32'd0;
      end
    end else begin
      mode          <= mode_next;
      field_index   <= field_index_next;
      char_position <= char_position_next;
      bad_flags     <= bad_flags_next;
      extra_flag    <= extra_flag_next;
      for (int i = 0; i < 4; i++) begin
        field_accum[i] <= field_accum_next[i];
      end
    end
  end

  always_comb begin
    rec.dev_addr        = field_accum[0][7:0];
    rec.target_reg      = field_accum[1];
    rec.write_data      = field_accum[2];
    rec.delay_value     = field_accum[3];
    rec.fields_found    = field_index;
    rec.bad_hex_mask    = bad_flags;
    rec.too_many_fields = extra_flag;
  end

endmodule

// File: hdl/hrsp_out_reg.sv
// Output register holding one finished record until the receiver takes it.
module hrsp_out_reg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  hrsp_pkg::record_t            rec,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [hrsp_pkg::REC_WIDTH-1:0] m_axis_tdata
);

  logic              out_valid, out_valid_next;
  hrsp_pkg::record_t out_rec;

  always_comb begin
    out_valid_next = out_valid && !m_axis_tready;
    if (load) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_rec <= rec;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_rec;

endmodule

// File: hdl/hrsp_checker.sv
// Port-level checks for the hex register script parser and their binding.
module hrsp_checker (
  input logic         clk,
  input logic         rst,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [111:0] m_axis_tdata
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("record valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled record changed");

  a_field_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[106:104] <= 3'd4)
    else $error("field count above four");

  a_extra_needs_four: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[111] |-> m_axis_tdata[106:104] == 3'd4)
    else $error("extra field flagged with fewer than four fields");

  a_bad_in_seen_field: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[110] |-> m_axis_tdata[106:104] == 3'd4)
    else $error("bad hex flag on a field that was never started");

endmodule

bind hex_register_script_parser_core hrsp_checker u_hrsp_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
